// ----- sv/hhms_pkg.sv -----
// hhms_pkg: shared types, character codes and digit helpers for the
// serial HHMMSS line parser. No dependencies.
`default_nettype none

package hhms_pkg;

   localparam int unsigned LINE_LEN = 6;
   localparam int unsigned FILL_W   = 3;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_LEN);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_error;
   } req_type;

   typedef struct packed {
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
   } rsp_type;

   // line store contents as seen by the decoder
   typedef struct packed {
      logic                    armed;
      logic [FILL_W-1:0]       fill_count;
      logic [LINE_LEN-1:0][7:0] chars;
   } line_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      logic r;
      r = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      return r;
   endfunction

   // 10*hi + lo from two ascii digits; low nibble of '0'..'9' is the value
   function automatic logic [6:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
      logic [6:0] h;
      logic [6:0] l;
      h = {3'b000, hi[3:0]};
      l = {3'b000, lo[3:0]};
      return (h << 3) + (h << 1) + l;
   endfunction

endpackage

`default_nettype wire

// ----- sv/serial_hhmmss_line_parser.sv -----
// serial_hhmmss_line_parser: top level with input register, line store,
// decoder and result register. Depends on hhms_pkg, hhms_line_store, hhms_time_decode.
`default_nettype none

// Takes one received byte per clock and emits hours/minutes/seconds when a
// newline closes a line whose first six stored characters are ascii digits
// (after the first newline since reset). Each item passes through the input
// register and then the result register, and rsp_valid rises when a decoded
// newline is loaded there; one item per cycle is sustained with no stall on
// the result side. A stall on rsp_stall holds the result register and backs
// up through the input register to req_stall.
module serial_hhmmss_line_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hhms_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hhms_pkg::rsp_type      rsp_data
);

   logic                      in_valid_ff;
   hhms_pkg::req_type         in_data_ff;
   logic                      rsp_valid_ff;
   hhms_pkg::rsp_type         rsp_data_ff;
   logic                      out_free;
   logic                      advance;
   logic                      dec_hit;
   hhms_pkg::rsp_type         dec_time;
   hhms_pkg::line_status_type status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   hhms_line_store u_store (
      .clock      (clock),
      .reset      (reset),
      .char_valid (advance),
      .char_data  (in_data_ff),
      .status     (status)
   );

   hhms_time_decode u_decode (
      .char_data (in_data_ff),
      .status    (status),
      .hit       (dec_hit),
      .time_out  (dec_time)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && dec_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec_hit) begin
         rsp_data_ff <= dec_time;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      status.fill_count <= hhms_pkg::FILL_FULL)
      else $error("fill count beyond line length");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_data_ff.frame_error && (in_data_ff.rx_byte == hhms_pkg::CHAR_LF))
      |=> (status.fill_count == '0) && status.armed)
      else $error("newline did not clear and arm the line store");

   a_hit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (advance && dec_hit) |=> rsp_valid_ff && (rsp_data_ff == $past(dec_time)))
      else $error("parsed time not loaded into result register");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> $stable(in_data_ff))
      else $error("input register overwritten while result side blocked");
`endif

endmodule

`default_nettype wire

// ----- sv/hhms_line_store.sv -----
// hhms_line_store: six-character line buffer with fill count and armed flag.
// Depends on hhms_pkg.
`default_nettype none

module hhms_line_store (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     char_valid,
   input  wire hhms_pkg::req_type        char_data,
   output hhms_pkg::line_status_type     status
);

   logic [7:0]                  store_ff [hhms_pkg::LINE_LEN];
   logic [hhms_pkg::FILL_W-1:0] fill_count_ff;
   logic [hhms_pkg::FILL_W-1:0] fill_count_in;
   logic                        armed_ff;
   logic                        armed_in;
   logic                        take;
   logic                        is_lf;
   logic                        do_store;

   assign take     = char_valid && !char_data.frame_error
                     && (char_data.rx_byte != hhms_pkg::CHAR_CR);
   assign is_lf    = char_data.rx_byte == hhms_pkg::CHAR_LF;
   assign do_store = take && !is_lf && (fill_count_ff < hhms_pkg::FILL_FULL);

   always_comb begin
      fill_count_in = fill_count_ff;
      armed_in      = armed_ff;
      if (take && is_lf) begin
         fill_count_in = '0;
         armed_in      = 1'b1;
      end else if (do_store) begin
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         armed_ff      <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         armed_ff      <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         store_ff[fill_count_ff] <= char_data.rx_byte;
      end
   end

   always_comb begin
      status.armed      = armed_ff;
      status.fill_count = fill_count_ff;
      for (int i = 0; i < hhms_pkg::LINE_LEN; i++) begin
         status.chars[i] = store_ff[i];
      end
   end

endmodule

`default_nettype wire

// ----- sv/hhms_time_decode.sv -----
// hhms_time_decode: checks a full armed line on newline and converts the
// six digits to hours, minutes, seconds. Depends on hhms_pkg.
`default_nettype none

module hhms_time_decode (
   input  wire hhms_pkg::req_type         char_data,
   input  wire hhms_pkg::line_status_type status,
   output logic                           hit,
   output hhms_pkg::rsp_type              time_out
);

   logic all_digits;

   always_comb begin
      all_digits = 1'b1;
      for (int i = 0; i < hhms_pkg::LINE_LEN; i++) begin
         if (!hhms_pkg::is_digit(status.chars[i])) begin
            all_digits = 1'b0;
         end
      end
   end

   assign hit = !char_data.frame_error
                && (char_data.rx_byte == hhms_pkg::CHAR_LF)
                && status.armed
                && (status.fill_count == hhms_pkg::FILL_FULL)
                && all_digits;

   assign time_out.hours   = hhms_pkg::pair_value(status.chars[0], status.chars[1]);
   assign time_out.minutes = hhms_pkg::pair_value(status.chars[2], status.chars[3]);
   assign time_out.seconds = hhms_pkg::pair_value(status.chars[4], status.chars[5]);

endmodule

`default_nettype wire

// ----- tb/serial_hhmmss_line_parser_tb.sv -----
// serial_hhmmss_line_parser_tb: directed table plus random line traffic against a
// behavioral line parser, with random idling on both channels. Depends on hhms_pkg
// and serial_hhmmss_line_parser.
`timescale 1ns / 100ps

module serial_hhmmss_line_parser_tb;

   localparam int unsigned RANDOM_BYTES   = 900;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned PAUSE_LINE     = 40;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} check_kind_type;
   typedef enum logic [2:0] {
      LINE_GOOD, LINE_LONG, LINE_SHORT, LINE_BAD, LINE_NOISE
   } line_shape_type;

   typedef struct packed {
      logic [7:0]        rx_byte;
      logic              frame_error;
      check_kind_type    how;
      hhms_pkg::rsp_type typed;
   } directed_row_type;

   localparam hhms_pkg::rsp_type BLANK_TIME = '{hours: 7'd0, minutes: 7'd0, seconds: 7'd0};
   localparam hhms_pkg::rsp_type ALL_NINES  = '{hours: 7'd99, minutes: 7'd99, seconds: 7'd99};

   localparam int unsigned N_DIRECTED = 27;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'hFF,             1'b1, CHECK_MODEL, BLANK_TIME}, // framing error on the top byte
      '{"1",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"2",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"3",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"4",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"5",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"6",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{hhms_pkg::CHAR_LF, 1'b0, CHECK_NONE,  BLANK_TIME}, // first line after reset is dropped
      '{"0",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"0",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{hhms_pkg::CHAR_CR, 1'b0, CHECK_MODEL, BLANK_TIME}, // carriage return is not stored
      '{":",               1'b0, CHECK_MODEL, BLANK_TIME}, // just above '9'
      '{"0",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"0",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"0",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{hhms_pkg::CHAR_LF, 1'b0, CHECK_NONE,  BLANK_TIME}, // non-digit line
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{"9",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{8'h00,             1'b0, CHECK_MODEL, BLANK_TIME}, // store full, dropped
      '{hhms_pkg::CHAR_LF, 1'b1, CHECK_MODEL, BLANK_TIME}, // newline with framing error
      '{hhms_pkg::CHAR_LF, 1'b0, CHECK_TYPED, ALL_NINES},
      '{"5",               1'b0, CHECK_MODEL, BLANK_TIME},
      '{hhms_pkg::CHAR_LF, 1'b0, CHECK_NONE,  BLANK_TIME}  // short line
   };

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   hhms_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   hhms_pkg::rsp_type rsp_data;

   // behavioral copy of the line parser
   logic [7:0]  line_chars [hhms_pkg::LINE_LEN];
   int unsigned chars_held   = 0;
   bit          seen_newline = 1'b0;

   hhms_pkg::rsp_type expected_times [$];
   hhms_pkg::req_type line_bytes [$];
   int unsigned       error_count = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       bytes_used  = 0;
   bit                no_idle     = 1'b0;

   serial_hhmmss_line_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [6:0] decimal_pair(input int unsigned idx);
      return 7'((line_chars[idx] - hhms_pkg::CHAR_ZERO) * 8'd10
                + (line_chars[idx + 1] - hhms_pkg::CHAR_ZERO));
   endfunction

   function automatic void take_byte(input hhms_pkg::req_type item, output bit got,
                                     output hhms_pkg::rsp_type t);
      bit all_digits;
      got = 1'b0;
      t   = BLANK_TIME;
      if (item.frame_error || item.rx_byte == hhms_pkg::CHAR_CR) return;
      if (item.rx_byte == hhms_pkg::CHAR_LF) begin
         if (seen_newline && chars_held == hhms_pkg::LINE_LEN) begin
            all_digits = 1'b1;
            foreach (line_chars[k])
               if (line_chars[k] < hhms_pkg::CHAR_ZERO || line_chars[k] > hhms_pkg::CHAR_NINE)
                  all_digits = 1'b0;
            if (all_digits) begin
               got       = 1'b1;
               t.hours   = decimal_pair(0);
               t.minutes = decimal_pair(2);
               t.seconds = decimal_pair(4);
            end
         end
         chars_held   = 0;
         seen_newline = 1'b1;
      end else if (chars_held < hhms_pkg::LINE_LEN) begin
         line_chars[chars_held] = item.rx_byte;
         chars_held++;
      end
   endfunction

   function automatic logic [7:0] digit_char();
      return hhms_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // anything that lands in the store and is not a digit when asked
   function automatic logic [7:0] stored_char(input bit non_digit);
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == hhms_pkg::CHAR_LF || c == hhms_pkg::CHAR_CR
             || (non_digit && c >= hhms_pkg::CHAR_ZERO && c <= hhms_pkg::CHAR_NINE));
      return c;
   endfunction

   // occasionally slip a dropped byte in ahead of the real one
   function automatic void add_char(input logic [7:0] c);
      hhms_pkg::req_type r;
      if ($urandom_range(0, 15) == 0) begin
         r.rx_byte     = ($urandom_range(0, 3) == 0) ? hhms_pkg::CHAR_LF
                                                     : 8'($urandom_range(0, 255));
         r.frame_error = 1'b1;
         line_bytes.push_back(r);
      end
      if ($urandom_range(0, 15) == 0) begin
         r.rx_byte     = hhms_pkg::CHAR_CR;
         r.frame_error = 1'b0;
         line_bytes.push_back(r);
      end
      r.rx_byte     = c;
      r.frame_error = 1'b0;
      line_bytes.push_back(r);
   endfunction

   function automatic void build_line();
      int unsigned       w;
      int unsigned       n;
      int unsigned       bad_pos;
      line_shape_type    shape;
      logic [7:0]        fill;
      hhms_pkg::req_type r;
      line_bytes.delete();
      w = $urandom_range(0, 9);
      shape = line_shape_type'((w < 6) ? LINE_GOOD : (w == 6) ? LINE_LONG :
                               (w == 7) ? LINE_SHORT : (w == 8) ? LINE_BAD : LINE_NOISE);
      case (shape)
         LINE_GOOD: begin
            w = $urandom_range(0, 7);
            fill = (w == 0) ? hhms_pkg::CHAR_ZERO : hhms_pkg::CHAR_NINE;
            for (int i = 0; i < hhms_pkg::LINE_LEN; i++)
               add_char((w < 2) ? fill : digit_char());
         end
         LINE_LONG: begin
            for (int i = 0; i < hhms_pkg::LINE_LEN; i++) add_char(digit_char());
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_char(stored_char(1'b0));
         end
         LINE_SHORT: begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) add_char(digit_char());
         end
         LINE_BAD: begin
            bad_pos = $urandom_range(0, hhms_pkg::LINE_LEN - 1);
            for (int i = 0; i < hhms_pkg::LINE_LEN; i++)
               add_char((i == bad_pos) ? stored_char(1'b1) : digit_char());
         end
         default: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               r.rx_byte     = 8'($urandom_range(0, 255));
               r.frame_error = 1'($urandom_range(0, 1));
               line_bytes.push_back(r);
            end
         end
      endcase
      if (shape != LINE_NOISE) add_char(hhms_pkg::CHAR_LF);
   endfunction

   task automatic send_byte(input hhms_pkg::req_type item, input check_kind_type how,
                            input hhms_pkg::rsp_type typed);
      int unsigned       gap;
      bit                got;
      hhms_pkg::rsp_type t;
      gap = idle_draw();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      take_byte(item, got, t);
      case (how)
         CHECK_MODEL: if (got) expected_times.push_back(t);
         CHECK_TYPED: expected_times.push_back(typed);
         default: ;
      endcase
      bytes_used++;
      if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
   endtask

   task automatic wait_for_times();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_times.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned       line_no;
      hhms_pkg::req_type r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         r.rx_byte     = DIRECTED_ROWS[i].rx_byte;
         r.frame_error = DIRECTED_ROWS[i].frame_error;
         send_byte(r, DIRECTED_ROWS[i].how, DIRECTED_ROWS[i].typed);
      end
      wait_for_times();

      bytes_used = 0;
      line_no    = 0;
      while (bytes_used < RANDOM_BYTES) begin
         build_line();
         foreach (line_bytes[i]) send_byte(line_bytes[i], CHECK_MODEL, BLANK_TIME);
         line_no++;
         if (line_no == PAUSE_LINE) wait_for_times();
      end

      wait_for_times();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_times.size() == 0)
         $display("[serial_hhmmss_line_parser] OK");
      else
         $display("[serial_hhmmss_line_parser] ERROR");
      $finish;
   end

   // result side stalls a random number of cycles ahead of each item
   initial begin : rsp_backpressure
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         hold = idle_draw();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      hhms_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_valid && !rsp_stall) begin
         if (expected_times.size() == 0) begin
            $error("unexpected time item: %0d:%0d:%0d",
                   rsp_data.hours, rsp_data.minutes, rsp_data.seconds);
            error_count++;
         end else begin
            want = expected_times.pop_front();
            if (rsp_data.hours !== want.hours) begin
               $error("hours: expected %0d, got %0d", want.hours, rsp_data.hours);
               error_count++;
            end
            if (rsp_data.minutes !== want.minutes) begin
               $error("minutes: expected %0d, got %0d", want.minutes, rsp_data.minutes);
               error_count++;
            end
            if (rsp_data.seconds !== want.seconds) begin
               $error("seconds: expected %0d, got %0d", want.seconds, rsp_data.seconds);
               error_count++;
            end
         end
      end
   end

   // no progress on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[serial_hhmmss_line_parser] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
